// ----- rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

  // Default screen geometry.
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Field widths of the input and result beats.
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int RROW_W   = 5;
  localparam int RCOL_W   = 7;
  localparam int CELL_W   = 16;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int ATTR_W   = 8;

  // Widest cursor over the supported geometry range.
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_CELL = 2'd1;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // Reset values and special characters.
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Command from the sequencer to the cursor unit.
  typedef struct packed {
    logic step;
    logic newline;
  } cur_cmd_t;

  // Cursor position and whether the pending step scrolls.
  typedef struct packed {
    logic [CUR_COL_W-1:0] col;
    logic [CUR_ROW_W-1:0] row;
    logic                 scroll;
  } cur_stat_t;

endpackage

// ----- rtl/tcw_if.sv -----
`timescale 1ns / 1ps

// Input channel: one console operation per beat.
interface tcw_in_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0]   char_code;
  logic [RROW_W-1:0]   read_row;
  logic [RCOL_W-1:0]   read_col;

  modport source (output valid, opcode, char_code, read_row, read_col, input ready);
  modport sink (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

// Result channel: one result per operation.
interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [OCOL_W-1:0] cursor_col;
  logic [OROW_W-1:0] cursor_row;
  logic              scrolled;

  modport source (output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
  modport sink (input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

// ----- rtl/tcw_ram.sv -----
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tcw_cursor.sv -----
`timescale 1ns / 1ps

module tcw_cursor import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cur_cmd_t  cmd,
  output cur_stat_t stat
);

  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          scroll;

  // Advance, wrap at the right edge or on a newline, and clamp to the last row on scroll.
  always_comb begin
    col_inc = {1'b0, col_r} + 1'b1;
    row_inc = {1'b0, row_r} + 1'b1;
    col_nxt = col_r;
    row_nxt = row_r;
    scroll  = 1'b0;
    if (cmd.step) begin
      if (cmd.newline || col_inc == (CW+1)'(COLS)) begin
        col_nxt = '0;
        if (row_inc == (RW+1)'(ROWS)) begin
          row_nxt = RW'(ROWS - 1);
          scroll  = 1'b1;
        end else begin
          row_nxt = row_inc[RW-1:0];
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign stat.col    = CUR_COL_W'(col_r);
  assign stat.row    = CUR_ROW_W'(row_r);
  assign stat.scroll = scroll;

endmodule

// ----- rtl/text_console_cell_writer.sv -----
`timescale 1ns / 1ps

// Text console engine holding a ROWS x COLS screen of 16-bit cells (attribute
// in the high byte, character in the low byte) and a cursor, all cells kept in
// one single-port-write, registered-read RAM. Operations are taken one at a
// time and each gives one result beat. A put that scrolls walks the RAM: one
// cell is copied up per cycle and then the bottom row is filled. A clear
// writes one cell per cycle. After reset the RAM is filled with the blank cell
// while no operation is accepted; configuration writes are taken at any time,
// but should only be issued while no operation is in progress.
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_if,
  tcw_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam logic [AW-1:0] LAST_ADDR   = AW'(N - 1);
  localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLS);
  localparam logic [AW-1:0] BOTTOM_ADDR = AW'(N - COLS);

  // Sequencer states.
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PUT    = 4'd2;
  localparam logic [3:0] S_READ   = 4'd3;
  localparam logic [3:0] S_RDATA  = 4'd4;
  localparam logic [3:0] S_SCROLL = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_FILL   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [ATTR_W-1:0]   attr_r;
  logic [CELL_W-1:0]   blank_r;

  // Captured operation.
  logic [OPCODE_W-1:0] op_r;
  logic [CHAR_W-1:0]   ch_r;
  logic [RROW_W-1:0]   rr_r;
  logic [RCOL_W-1:0]   rc_r;

  // Result being built and the output register.
  logic [CELL_W-1:0]   res_cell_r, res_cell_nxt;
  logic                res_scroll_r, res_scroll_nxt;
  logic                out_valid_r;
  logic [CELL_W-1:0]   out_cell_r;
  logic [OCOL_W-1:0]   out_col_r;
  logic [OROW_W-1:0]   out_row_r;
  logic                out_scroll_r;
  logic                out_load;

  // Scroll copy pipeline: the write of a cell comes in the cycle after its read.
  logic                cp_vld_r;
  logic [AW-1:0]       cp_dst_r;

  // RAM ports.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                accept;
  logic                is_newline;
  logic                rd_in_range;
  logic [AW-1:0]       cur_addr;
  logic [AW-1:0]       rd_addr;
  cur_cmd_t            cur_cmd;
  cur_stat_t           cur_stat;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cur_cmd),
    .stat  (cur_stat)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign is_newline  = (ch_r == NEWLINE_CODE);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  assign cur_cmd.step    = (state_r == S_PUT);
  assign cur_cmd.newline = is_newline;

  // Cell addresses of the cursor and of the requested read.
  assign cur_addr    = AW'(cur_stat.row) * ROW_STRIDE + AW'(cur_stat.col);
  assign rd_in_range = (7'(rr_r) < 7'(ROWS)) && (8'(rc_r) < 8'(COLS));
  assign rd_addr     = AW'(rr_r) * ROW_STRIDE + AW'(rc_r);

  // RAM read address: the scroll source or the requested cell.
  assign ram_raddr = (state_r == S_SCROLL) ? idx_r : rd_addr;

  // RAM write port: copy write, fill write or character write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = blank_r;
    if (cp_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = cp_dst_r;
      ram_wdata = ram_rdata;
    end else if (state_r == S_INIT) begin
      ram_we    = 1'b1;
      ram_wdata = BLANK_RESET;
    end else if (state_r == S_FILL) begin
      ram_we    = 1'b1;
    end else if (state_r == S_PUT && !is_newline) begin
      ram_we    = 1'b1;
      ram_waddr = cur_addr;
      ram_wdata = {attr_r, ch_r};
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    res_cell_nxt   = res_cell_r;
    res_scroll_nxt = res_scroll_r;
    case (state_r)
      S_INIT: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_cell_nxt   = '0;
          res_scroll_nxt = 1'b0;
          case (in_if.opcode)
            OP_PUT:   state_nxt = S_PUT;
            OP_READ:  state_nxt = S_READ;
            OP_CLEAR: begin
              idx_nxt      = '0;
              res_cell_nxt = blank_r;
              state_nxt    = S_FILL;
            end
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        res_cell_nxt = is_newline ? '0 : {attr_r, ch_r};
        if (cur_stat.scroll) begin
          res_scroll_nxt = 1'b1;
          idx_nxt        = ROW_STRIDE;
          state_nxt      = S_SCROLL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        res_cell_nxt = rd_in_range ? ram_rdata : '0;
        state_nxt    = S_DONE;
      end
      S_SCROLL: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_ADDR) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        idx_nxt   = BOTTOM_ADDR;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_ADDR) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      idx_r    <= '0;
      cp_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cp_vld_r <= (state_r == S_SCROLL);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cp_dst_r     <= idx_r - ROW_STRIDE;
    res_cell_r   <= res_cell_nxt;
    res_scroll_r <= res_scroll_nxt;
    if (accept) begin
      op_r <= in_if.opcode;
      ch_r <= in_if.char_code;
      rr_r <= in_if.read_row;
      rc_r <= in_if.read_col;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r  <= ATTR_RESET;
      blank_r <= BLANK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_ATTR:  attr_r  <= cfg_wdata[ATTR_W-1:0];
        REG_BLANK_CELL: blank_r <= cfg_wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register; the result beat waits here until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell_r   <= res_cell_r;
      out_col_r    <= OCOL_W'(cur_stat.col);
      out_row_r    <= OROW_W'(cur_stat.row);
      out_scroll_r <= res_scroll_r && (op_r == OP_PUT);
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.cell_value = out_cell_r;
  assign out_if.cursor_col = out_col_r;
  assign out_if.cursor_row = out_row_r;
  assign out_if.scrolled   = out_scroll_r;

endmodule

// ----- rtl/tcw_checker.sv -----
`timescale 1ns / 1ps

module tcw_checker import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [OCOL_W-1:0] cursor_col,
  input logic [OROW_W-1:0] cursor_row,
  input logic              scrolled
);

  // A result beat is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // Operations are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("operation accepted while another is in progress");

  // The reported cursor column stays on the screen.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, cursor_col} < 8'(COLS)))
    else $error("cursor column off the screen");

  // A scroll always leaves the cursor on the last row at column zero.
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && scrolled |-> (cursor_row == OROW_W'(ROWS - 1)) && (cursor_col == '0))
    else $error("scroll left the cursor off the last row");

endmodule

bind text_console_cell_writer tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .cursor_col (out_if.cursor_col),
  .cursor_row (out_if.cursor_row),
  .scrolled   (out_if.scrolled)
);
